[rtl/mhpq_pkg.sv]
// Package for the min-heap priority queue: sizes, command codes and the
// input / result word types. No dependencies.
package mhpq_pkg;

  localparam int HEAP_DEPTH    = 256;
  localparam int ADDR_W        = $clog2(HEAP_DEPTH);
  localparam int CNT_W         = $clog2(HEAP_DEPTH + 1);
  localparam int IDX_W         = ADDR_W + 2;
  localparam int KEY_W         = 32;
  localparam int ENTRY_COUNT_W = 9;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef struct packed {
    logic                    command;
    logic signed [KEY_W-1:0] value;
  } mhpq_in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]    result_value;
    logic                       accepted;
    logic [ENTRY_COUNT_W-1:0]   entry_count;
  } mhpq_out_t;

endpackage

[rtl/min_heap_priority_queue.sv]
// Insert: places the key after the last entry and climbs toward the root while the parent is larger.
// Delete-min: returns the root, moves the last entry to the root and sinks it while a child is smaller.
// A refused insert (full) or delete (empty) is answered straight from ST_IDLE.
// Each level reads the heap RAM (CHK state), then compares and writes back (CMP state).
// Synchronous active-low reset empties the heap; RAM contents are not cleared.
module min_heap_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mhpq_pkg::mhpq_in_t in_data,
  output logic               out_valid,
  output mhpq_pkg::mhpq_out_t out_data
);
  import mhpq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UP_CHK, ST_UP_CMP, ST_DN_LOAD, ST_DN_CHK, ST_DN_CMP
  } state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [ADDR_W-1:0]       pos_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] res_r;
  logic                    out_valid_r;
  mhpq_out_t               out_r;

  // heap RAM: one write port, two registered read ports
  logic signed [KEY_W-1:0] mem [HEAP_DEPTH];
  logic                    we;
  logic [ADDR_W-1:0]       wa, ra0, ra1;
  logic signed [KEY_W-1:0] wd, rd0_r, rd1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  logic [CNT_W-1:0]        cnt_m1;
  logic [IDX_W-1:0]        left_idx, right_idx, cnt_ext;
  logic [ADDR_W-1:0]       parent, pick;
  logic                    right_ok, up_move, dn_move;
  logic signed [KEY_W-1:0] pick_val;
  logic                    accept;

  assign accept    = start && !busy;
  assign cnt_m1    = cnt_r - 1'b1;
  assign cnt_ext   = IDX_W'(cnt_r);
  assign left_idx  = IDX_W'({pos_r, 1'b1});
  assign right_idx = left_idx + 1'b1;
  assign parent    = (pos_r - 1'b1) >> 1;
  assign right_ok  = right_idx < cnt_ext;
  // left wins a tie
  assign pick      = (right_ok && rd0_r > rd1_r) ? right_idx[ADDR_W-1:0]
                                                 : left_idx[ADDR_W-1:0];
  assign pick_val  = (right_ok && rd0_r > rd1_r) ? rd1_r : rd0_r;
  assign up_move   = key_r < rd0_r;
  assign dn_move   = pick_val < key_r;

  always_comb begin
    we  = 1'b0;
    wa  = pos_r;
    wd  = key_r;
    ra0 = '0;
    ra1 = '0;
    unique case (state_r)
      ST_IDLE: begin
        ra1 = cnt_m1[ADDR_W-1:0];
      end
      ST_UP_CHK: begin
        ra0 = parent;
        we  = (pos_r == '0);
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (up_move) begin
          wd = rd0_r;
        end
      end
      ST_DN_LOAD: begin
      end
      ST_DN_CHK: begin
        ra0 = left_idx[ADDR_W-1:0];
        ra1 = right_idx[ADDR_W-1:0];
        we  = !(left_idx < cnt_ext);
      end
      ST_DN_CMP: begin
        we = 1'b1;
        if (dn_move) begin
          wd = pick_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_data.command == CMD_INSERT) begin
              res_r <= '0;
              if (cnt_r == CNT_W'(HEAP_DEPTH)) begin
                out_valid_r <= 1'b1;
                out_r       <= '{result_value: '0, accepted: 1'b0,
                                 entry_count: ENTRY_COUNT_W'(cnt_r)};
              end else begin
                key_r   <= in_data.value;
                pos_r   <= cnt_r[ADDR_W-1:0];
                cnt_r   <= cnt_r + 1'b1;
                state_r <= ST_UP_CHK;
              end
            end else begin
              if (cnt_r == '0) begin
                out_valid_r <= 1'b1;
                out_r       <= '{result_value: '0, accepted: 1'b0,
                                 entry_count: ENTRY_COUNT_W'(cnt_r)};
              end else begin
                cnt_r   <= cnt_m1;
                state_r <= ST_DN_LOAD;
              end
            end
          end
        end
        ST_UP_CHK: begin
          if (pos_r == '0) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            out_r       <= '{result_value: res_r, accepted: 1'b1,
                             entry_count: ENTRY_COUNT_W'(cnt_r)};
          end else begin
            state_r <= ST_UP_CMP;
          end
        end
        ST_UP_CMP: begin
          if (up_move) begin
            pos_r   <= parent;
            state_r <= ST_UP_CHK;
          end else begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            out_r       <= '{result_value: res_r, accepted: 1'b1,
                             entry_count: ENTRY_COUNT_W'(cnt_r)};
          end
        end
        ST_DN_LOAD: begin
          // root and last entry arrive together
          res_r   <= rd0_r;
          key_r   <= rd1_r;
          pos_r   <= '0;
          state_r <= ST_DN_CHK;
        end
        ST_DN_CHK: begin
          if (!(left_idx < cnt_ext)) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            out_r       <= '{result_value: res_r, accepted: 1'b1,
                             entry_count: ENTRY_COUNT_W'(cnt_r)};
          end else begin
            state_r <= ST_DN_CMP;
          end
        end
        ST_DN_CMP: begin
          if (dn_move) begin
            pos_r   <= pick;
            state_r <= ST_DN_CHK;
          end else begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            out_r       <= '{result_value: res_r, accepted: 1'b1,
                             entry_count: ENTRY_COUNT_W'(cnt_r)};
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/mhpq_checker.sv]
// Port-level checks for the min-heap priority queue, bound to the top level.
// Depends on mhpq_pkg.
module mhpq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input mhpq_pkg::mhpq_in_t  in_data,
  input logic                out_valid,
  input mhpq_pkg::mhpq_out_t out_data
);
  import mhpq_pkg::*;

  // an accepted word is either in flight or answered next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted word neither busy nor answered");

  // leaving busy always coincides with a result
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (busy ##1 !busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.accepted) |-> (out_data.result_value == '0))
    else $error("refused word carries a value");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.entry_count <= ENTRY_COUNT_W'(HEAP_DEPTH)))
    else $error("entry count beyond depth");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

[bench/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for min_heap_priority_queue: drives insert / delete-min words
// and checks every result word against an in-bench heap predictor.
// Depends on rtl/mhpq_pkg.sv and rtl/min_heap_priority_queue.sv.
module tb;
  import mhpq_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  mhpq_in_t  in_data = '0;
  logic      out_valid;
  mhpq_out_t out_data;

  // predictor state
  logic signed [KEY_W-1:0] heap_model [HEAP_DEPTH];
  int                      heap_count = 0;

  mhpq_out_t expected_results [$];
  mhpq_out_t want;
  int        fail_count = 0;
  int        idle_pct = 0;

  min_heap_priority_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one command to the predicted heap and returns the result word it should give.
  function automatic mhpq_out_t predict_heap_op(input mhpq_in_t w);
    mhpq_out_t               r;
    logic signed [KEY_W-1:0] key;
    int                      pos;
    int                      up;
    int                      pick;
    r = '0;
    if (w.command == CMD_INSERT) begin
      if (heap_count < HEAP_DEPTH) begin
        pos = heap_count;
        key = w.value;
        heap_count++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(key < heap_model[up])) break;
          heap_model[pos] = heap_model[up];
          pos = up;
        end
        heap_model[pos] = key;
        r.accepted = 1'b1;
      end
    end else if (heap_count > 0) begin
      r.result_value = heap_model[0];
      heap_count--;
      key = heap_model[heap_count];
      pos = 0;
      // smaller child wins, left on a tie; move only while strictly smaller
      while (2 * pos + 1 < heap_count) begin
        pick = 2 * pos + 1;
        if (pick + 1 < heap_count && heap_model[pick] > heap_model[pick + 1]) pick++;
        if (!(heap_model[pick] < key)) break;
        heap_model[pos] = heap_model[pick];
        pos = pick;
      end
      heap_model[pos] = key;
      r.accepted = 1'b1;
    end
    r.entry_count = ENTRY_COUNT_W'(heap_count);
    return r;
  endfunction

  // Offers one word; returns at the edge that accepts it, or after a random gap.
  task automatic send_word(input logic cmd, input logic signed [KEY_W-1:0] val);
    mhpq_in_t w;
    w.command = cmd;
    w.value   = val;
    in_data <= w;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_heap_op(w));
    if ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= {1'($urandom), KEY_W'($urandom)};
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: value %0d", out_data.result_value);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.result_value !== want.result_value) begin
          $error("result_value: expected %0d, got %0d", want.result_value,
                 out_data.result_value);
          fail_count++;
        end
        if (out_data.accepted !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, out_data.accepted);
          fail_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_data.entry_count);
          fail_count++;
        end
      end
    end
  end

  task automatic test_empty_delete();
    send_word(CMD_DELETE, 32'sd0);
    send_word(CMD_DELETE, 32'sh7FFFFFFF);
  endtask

  task automatic test_key_extremes();
    send_word(CMD_INSERT, 32'sh7FFFFFFF);
    send_word(CMD_INSERT, 32'sh80000000);
    send_word(CMD_INSERT, 32'sd0);
    send_word(CMD_INSERT, -32'sd1);
    send_word(CMD_INSERT, 32'sd1);
    repeat (6) send_word(CMD_DELETE, 32'sd0);
  endtask

  task automatic test_equal_keys();
    send_word(CMD_INSERT, 32'sd3);
    send_word(CMD_INSERT, 32'sd3);
    send_word(CMD_INSERT, -32'sd3);
    send_word(CMD_INSERT, 32'sd3);
    send_word(CMD_INSERT, -32'sd3);
    repeat (5) send_word(CMD_DELETE, 32'sd0);
  endtask

  // fills to the top, tries two inserts that must be refused, then takes 30 entries off the full heap
  task automatic test_fill_and_drain();
    repeat (HEAP_DEPTH) send_word(CMD_INSERT, KEY_W'($urandom));
    send_word(CMD_INSERT, 32'sh80000000);
    send_word(CMD_INSERT, 32'sh7FFFFFFF);
    repeat (30) send_word(CMD_DELETE, 32'sd0);
  endtask

  task automatic test_random_mix(input int n, input int pct);
    int                      ins_pct;
    logic signed [KEY_W-1:0] val;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      // steer the count so the heap gets deep but also empties now and then
      ins_pct = (heap_count < 8) ? 70 : (heap_count > 200) ? 30 : 55;
      case ($urandom_range(3))
        0, 1: val = KEY_W'($urandom);
        2:    val = KEY_W'(int'($urandom_range(8)) - 4);
        default: val = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      endcase
      send_word(($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_DELETE, val);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 25;
    test_empty_delete();
    test_key_extremes();
    test_equal_keys();
    test_fill_and_drain();
    test_random_mix(50, 25);
    test_random_mix(50, 64);
    test_random_mix(50, 0);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
